>>> hdl/ccps_pkg.sv
package ccps_pkg;

	// default coordinate fraction width (Q12.4)
	localparam int COORD_FRAC_BITS_DEF = 4;
	// fraction bits of the segment parameter t
	localparam int T_BITS = 16;
	// fraction bits of radius, distance and coverage
	localparam int ACC_FRAC = 20;

	// how t is formed for a pixel
	typedef enum logic [1:0] {
		TM_ZERO,
		TM_ONE,
		TM_DIV
	} tmode_t;

endpackage

>>> hdl/ccps_div.sv
module ccps_div #(
	parameter int DVW = 36,
	parameter int QW  = ccps_pkg::T_BITS + 1,
	parameter int SBW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [DVW+QW-1:0]  num,
	input  logic [DVW-1:0]     den,
	input  logic [SBW-1:0]     side_in,
	output logic               out_vld,
	output logic [QW-1:0]      quot,
	output logic [SBW-1:0]     side_out
);
	// restoring divider, one quotient bit per stage; quotient known to fit QW bits

	logic           vld_s  [QW];
	logic [DVW-1:0] rem_s  [QW];
	logic [QW-1:0]  quot_s [QW];
	logic [QW-1:0]  low_s  [QW];
	logic [DVW-1:0] den_s  [QW];
	logic [SBW-1:0] side_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic           vld_p;
		logic [DVW-1:0] rem_p;
		logic [QW-1:0]  quot_p;
		logic [QW-1:0]  low_p;
		logic [DVW-1:0] den_p;
		logic [SBW-1:0] side_p;
		logic [DVW:0]   cand;
		logic [DVW:0]   diff;
		logic           ge;

		if (i == 0) begin : g_first
			assign vld_p  = in_vld;
			assign rem_p  = num[DVW+QW-1:QW];
			assign quot_p = '0;
			assign low_p  = num[QW-1:0];
			assign den_p  = den;
			assign side_p = side_in;
		end else begin : g_next
			assign vld_p  = vld_s[i-1];
			assign rem_p  = rem_s[i-1];
			assign quot_p = quot_s[i-1];
			assign low_p  = low_s[i-1];
			assign den_p  = den_s[i-1];
			assign side_p = side_s[i-1];
		end

		// shift in next numerator bit, trial subtract
		assign cand = {rem_p, low_p[QW-1-i]};
		assign diff = cand - {1'b0, den_p};
		assign ge   = (cand >= {1'b0, den_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? diff[DVW-1:0] : cand[DVW-1:0];
			quot_s[i] <= {quot_p[QW-2:0], ge};
			low_s[i]  <= low_p;
			den_s[i]  <= den_p;
			side_s[i] <= side_p;
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign quot     = quot_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

>>> hdl/ccps_sqrt.sv
module ccps_sqrt #(
	parameter int K   = 30,
	parameter int SBW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [2*K-1:0]   n,
	input  logic [SBW-1:0]   side_in,
	output logic             out_vld,
	output logic [K-1:0]     root,
	output logic [K:0]       rem,
	output logic [SBW-1:0]   side_out
);
	// digit-by-digit square root, one root bit per stage

	logic           vld_s  [K];
	logic [K:0]     rem_s  [K];
	logic [K-1:0]   root_s [K];
	logic [2*K-1:0] n_s    [K];
	logic [SBW-1:0] side_s [K];

	for (genvar i = 0; i < K; i++) begin : g_stage
		logic           vld_p;
		logic [K:0]     rem_p;
		logic [K-1:0]   root_p;
		logic [2*K-1:0] n_p;
		logic [SBW-1:0] side_p;
		logic [K+2:0]   cand;
		logic [K+2:0]   trial;
		logic [K+2:0]   diff;
		logic           ge;

		if (i == 0) begin : g_first
			assign vld_p  = in_vld;
			assign rem_p  = '0;
			assign root_p = '0;
			assign n_p    = n;
			assign side_p = side_in;
		end else begin : g_next
			assign vld_p  = vld_s[i-1];
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign n_p    = n_s[i-1];
			assign side_p = side_s[i-1];
		end

		// bring down two bits, try (4*root + 1)
		assign cand  = {rem_p, n_p[2*K-1-2*i -: 2]};
		assign trial = {1'b0, root_p, 2'b01};
		assign diff  = cand - trial;
		assign ge    = (cand >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? diff[K:0] : cand[K:0];
			root_s[i] <= {root_p[K-2:0], ge};
			n_s[i]    <= n_p;
			side_s[i] <= side_p;
		end
	end

	assign out_vld  = vld_s[K-1];
	assign root     = root_s[K-1];
	assign rem      = rem_s[K-1];
	assign side_out = side_s[K-1];

endmodule

>>> hdl/capsule_coverage_pixel_shader.sv
// A pixel passes stages 1-4, the t divider, stages 5-8, the square root and stages 9-11 to done;
// the t divider has 17 stages and the square root K (its width, 30 by default), one bit each.
// Throughput: one pixel per clock; busy stays low, a new start is taken every cycle.
// Each result shows for one cycle with done; the receiver cannot stall.
// Reset (arst_n low) clears all valid bits at once; pixels in flight are dropped.
module capsule_coverage_pixel_shader #(
	parameter int COORD_FRAC_BITS = ccps_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [11:0]        pixel_x,
	input  logic [11:0]        pixel_y,
	input  logic signed [16:0] start_x,
	input  logic signed [16:0] start_y,
	input  logic [7:0]         start_radius,
	input  logic signed [16:0] end_x,
	input  logic signed [16:0] end_y,
	input  logic [7:0]         end_radius,
	input  logic [7:0]         current_grey,
	output logic               done,
	output logic               covered,
	output logic [7:0]         new_grey
);
	import ccps_pkg::*;

	localparam int F    = COORD_FRAC_BITS;
	localparam int PXW  = 12 + F;
	localparam int DW   = ((PXW + 1 > 17) ? PXW + 1 : 17) + 1;
	localparam int AW   = 18;
	localparam int PW   = 2 * AW;
	localparam int LW   = 2 * AW;
	localparam int QW   = T_BITS + 1;
	localparam int NW   = LW + QW;
	localparam int DOTW = DW + AW + 1;
	localparam int DDW  = ((DW + T_BITS > 2 * AW) ? DW + T_BITS : 2 * AW) + 1;
	localparam int MW   = DDW - 8;
	localparam int K    = MW + 1;
	localparam int RW   = 27;
	localparam int SH   = ACC_FRAC - 8 - F;
	localparam int D20W = K + 1 + SH;
	localparam int CVW  = ((D20W + 1 > RW) ? D20W + 1 : RW) + 2;
	localparam longint DEG_LIM = (64'sd1 <<< (2 * F)) / 10000;
	localparam int SB1W = 2 + 2 * DW + 2 * AW + 24;
	localparam int SB2W = RW + 8;

	localparam logic signed [CVW-1:0] HALF_C = CVW'(1) << (ACC_FRAC - 1);
	localparam logic signed [CVW-1:0] ONE_C  = CVW'(1) << ACC_FRAC;

	assign busy = 1'b0;

	// ---- stage 1: pixel centre and differences
	logic                 vld_s1;
	logic signed [DW-1:0] pax_s1, pay_s1;
	logic signed [AW-1:0] abx_s1, aby_s1;
	logic [7:0]           r0_s1, r1_s1, cur_s1;
	logic [PXW-1:0]       px, py;

	assign px = {pixel_x, 1'b1, {(F - 1){1'b0}}};
	assign py = {pixel_y, 1'b1, {(F - 1){1'b0}}};

	always_ff @(posedge clk) begin
		pax_s1 <= DW'($signed({1'b0, px})) - DW'(start_x);
		pay_s1 <= DW'($signed({1'b0, py})) - DW'(start_y);
		abx_s1 <= AW'(end_x) - AW'(start_x);
		aby_s1 <= AW'(end_y) - AW'(start_y);
		r0_s1  <= start_radius;
		r1_s1  <= end_radius;
		cur_s1 <= current_grey;
	end

	// ---- stage 2: products for lensq and dot
	logic                      vld_s2;
	logic signed [PW-1:0]      abx2_s2, aby2_s2;
	logic signed [DW+AW-1:0]   pdx_s2, pdy_s2;
	logic signed [DW-1:0]      pax_s2, pay_s2;
	logic signed [AW-1:0]      abx_s2, aby_s2;
	logic [7:0]                r0_s2, r1_s2, cur_s2;

	always_ff @(posedge clk) begin
		abx2_s2 <= abx_s1 * abx_s1;
		aby2_s2 <= aby_s1 * aby_s1;
		pdx_s2  <= pax_s1 * abx_s1;
		pdy_s2  <= pay_s1 * aby_s1;
		pax_s2  <= pax_s1;
		pay_s2  <= pay_s1;
		abx_s2  <= abx_s1;
		aby_s2  <= aby_s1;
		r0_s2   <= r0_s1;
		r1_s2   <= r1_s1;
		cur_s2  <= cur_s1;
	end

	// ---- stage 3: lensq and dot sums
	logic                   vld_s3;
	logic [LW-1:0]          lensq_s3;
	logic signed [DOTW-1:0] dot_s3;
	logic signed [DW-1:0]   pax_s3, pay_s3;
	logic signed [AW-1:0]   abx_s3, aby_s3;
	logic [7:0]             r0_s3, r1_s3, cur_s3;

	always_ff @(posedge clk) begin
		lensq_s3 <= LW'($unsigned(abx2_s2)) + LW'($unsigned(aby2_s2));
		dot_s3   <= DOTW'(pdx_s2) + DOTW'(pdy_s2);
		pax_s3   <= pax_s2;
		pay_s3   <= pay_s2;
		abx_s3   <= abx_s2;
		aby_s3   <= aby_s2;
		r0_s3    <= r0_s2;
		r1_s3    <= r1_s2;
		cur_s3   <= cur_s2;
	end

	// ---- stage 4: t mode and divider numerator
	logic            vld_s4;
	logic [NW-1:0]   num_s4;
	logic [LW-1:0]   lensq_s4;
	logic [SB1W-1:0] sb1_s4;
	tmode_t          mode_c;

	always_comb begin
		if ((lensq_s3 <= LW'(DEG_LIM)) || (dot_s3 <= DOTW'(0))) begin
			mode_c = TM_ZERO;
		end else if (dot_s3 >= DOTW'($signed({1'b0, lensq_s3}))) begin
			mode_c = TM_ONE;
		end else begin
			mode_c = TM_DIV;
		end
	end

	always_ff @(posedge clk) begin
		num_s4   <= NW'({dot_s3[LW-1:0], {T_BITS{1'b0}}}) + NW'(lensq_s3[LW-1:1]);
		lensq_s4 <= lensq_s3;
		sb1_s4   <= {mode_c, pax_s3, pay_s3, abx_s3, aby_s3, r0_s3, r1_s3, cur_s3};
	end

	// ---- t divider
	logic            dvld;
	logic [QW-1:0]   quot;
	logic [SB1W-1:0] sb1_d;

	ccps_div #(
		.DVW (LW),
		.QW  (QW),
		.SBW (SB1W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.num      (num_s4),
		.den      (lensq_s4),
		.side_in  (sb1_s4),
		.out_vld  (dvld),
		.quot     (quot),
		.side_out (sb1_d)
	);

	tmode_t               d_mode;
	logic signed [DW-1:0] d_pax, d_pay;
	logic signed [AW-1:0] d_abx, d_aby;
	logic [7:0]           d_r0, d_r1, d_cur;
	logic [QW-1:0]        t_c;
	logic signed [8:0]    rdiff_c;

	assign d_mode = tmode_t'(sb1_d[SB1W-1 -: 2]);
	assign {d_pax, d_pay, d_abx, d_aby, d_r0, d_r1, d_cur} = sb1_d[SB1W-3:0];
	assign rdiff_c = $signed({1'b0, d_r1}) - $signed({1'b0, d_r0});

	always_comb begin
		case (d_mode)
			TM_ZERO: t_c = '0;
			TM_ONE:  t_c = QW'(1) << T_BITS;
			TM_DIV:  t_c = quot;
			default: t_c = '0;
		endcase
	end

	// ---- stage 5: t times segment and radius delta
	logic                   vld_s5;
	logic signed [PW-1:0]   abxt_s5, abyt_s5;
	logic signed [RW-1:0]   rt_s5;
	logic signed [DW-1:0]   pax_s5, pay_s5;
	logic [7:0]             r0_s5, cur_s5;

	always_ff @(posedge clk) begin
		abxt_s5 <= d_abx * $signed({1'b0, t_c});
		abyt_s5 <= d_aby * $signed({1'b0, t_c});
		rt_s5   <= rdiff_c * $signed({1'b0, t_c});
		pax_s5  <= d_pax;
		pay_s5  <= d_pay;
		r0_s5   <= d_r0;
		cur_s5  <= d_cur;
	end

	// ---- stage 6: distance components, rounded magnitudes; radius
	logic                  vld_s6;
	logic [MW-1:0]         mx_s6, my_s6;
	logic signed [RW-1:0]  r20_s6;
	logic [7:0]            cur_s6;
	logic signed [DDW-1:0] ddx_c, ddy_c;
	logic [DDW-1:0]        magx_c, magy_c, rndx_c, rndy_c;

	always_comb begin
		ddx_c  = (DDW'(pax_s5) <<< T_BITS) - DDW'(abxt_s5);
		ddy_c  = (DDW'(pay_s5) <<< T_BITS) - DDW'(abyt_s5);
		magx_c = ddx_c[DDW-1] ? $unsigned(-ddx_c) : $unsigned(ddx_c);
		magy_c = ddy_c[DDW-1] ? $unsigned(-ddy_c) : $unsigned(ddy_c);
		rndx_c = magx_c + DDW'(128);
		rndy_c = magy_c + DDW'(128);
	end

	always_ff @(posedge clk) begin
		mx_s6  <= rndx_c[DDW-1:8];
		my_s6  <= rndy_c[DDW-1:8];
		r20_s6 <= $signed({3'b000, r0_s5, {T_BITS{1'b0}}}) + rt_s5;
		cur_s6 <= cur_s5;
	end

	// ---- stage 7: squares
	logic                 vld_s7;
	logic [2*MW-1:0]      mx2_s7, my2_s7;
	logic signed [RW-1:0] r20_s7;
	logic [7:0]           cur_s7;

	always_ff @(posedge clk) begin
		mx2_s7 <= mx_s6 * mx_s6;
		my2_s7 <= my_s6 * my_s6;
		r20_s7 <= r20_s6;
		cur_s7 <= cur_s6;
	end

	// ---- stage 8: squared distance
	logic            vld_s8;
	logic [2*K-1:0]  n_s8;
	logic [SB2W-1:0] sb2_s8;

	always_ff @(posedge clk) begin
		n_s8   <= (2 * K)'(mx2_s7) + (2 * K)'(my2_s7);
		sb2_s8 <= {r20_s7, cur_s7};
	end

	// ---- square root
	logic            svld;
	logic [K-1:0]    root;
	logic [K:0]      rem;
	logic [SB2W-1:0] sb2_q;

	ccps_sqrt #(
		.K   (K),
		.SBW (SB2W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s8),
		.n        (n_s8),
		.side_in  (sb2_s8),
		.out_vld  (svld),
		.root     (root),
		.rem      (rem),
		.side_out (sb2_q)
	);

	// ---- stage 9: round to nearest, scale to accumulator fraction
	logic                 vld_s9;
	logic [D20W-1:0]      d20_s9;
	logic signed [RW-1:0] r20_s9;
	logic [7:0]           cur_s9;
	logic [K:0]           dq_c;

	assign dq_c = (K + 1)'(root) + (K + 1)'(rem > (K + 1)'(root));

	always_ff @(posedge clk) begin
		d20_s9 <= D20W'(dq_c) << SH;
		r20_s9 <= sb2_q[SB2W-1:8];
		cur_s9 <= sb2_q[7:0];
	end

	// ---- stage 10: coverage
	logic                  vld_s10;
	logic signed [CVW-1:0] cov_s10;
	logic [7:0]            cur_s10;

	always_ff @(posedge clk) begin
		cov_s10 <= CVW'(r20_s9) + HALF_C - CVW'($signed({1'b0, d20_s9}));
		cur_s10 <= cur_s9;
	end

	// ---- stage 11: clamp, ink, darker of ink and current
	logic                vld_s11;
	logic                covered_s11;
	logic [7:0]          grey_s11;
	logic                pos_c;
	logic [ACC_FRAC:0]   cl_c, inv_c;
	logic [27:0]         ink_sum_c;
	logic [7:0]          ink_c;

	always_comb begin
		pos_c     = !cov_s10[CVW-1] && (|cov_s10);
		cl_c      = (cov_s10 > ONE_C) ? (ACC_FRAC + 1)'(1) << ACC_FRAC
		                              : cov_s10[ACC_FRAC:0];
		inv_c     = ((ACC_FRAC + 1)'(1) << ACC_FRAC) - cl_c;
		ink_sum_c = {inv_c[19:0], 8'h00} - 28'(inv_c) + (28'(1) << (ACC_FRAC - 1));
		if (inv_c[ACC_FRAC]) begin
			ink_sum_c = 28'(255) << ACC_FRAC;
			ink_sum_c = ink_sum_c + (28'(1) << (ACC_FRAC - 1));
		end
		ink_c     = ink_sum_c[27:20];
	end

	always_ff @(posedge clk) begin
		covered_s11 <= vld_s10 && pos_c && (ink_c < cur_s10);
		grey_s11    <= (pos_c && (ink_c < cur_s10)) ? ink_c : cur_s10;
	end

	// ---- valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= dvld;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= svld;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	assign done     = vld_s11;
	assign covered  = covered_s11;
	assign new_grey = grey_s11;

`ifndef ASSERT_OFF
	// pipeline never pushes back
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	// a covered pixel only with a result beat
	a_cov_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		covered |-> done)
		else $error("covered without done");
	// covered ink is strictly darker than white
	a_cov_dark: assert property (@(posedge clk) disable iff (!arst_n)
		covered |-> (new_grey != 8'hFF))
		else $error("covered pixel left white");
`endif

endmodule

>>> dv/tb_capsule_coverage_pixel_shader.sv
`timescale 1ns / 100ps

module tb_capsule_coverage_pixel_shader;

	localparam int FRAC = ccps_pkg::COORD_FRAC_BITS_DEF;
	localparam longint T_ONE = 64'd1 << ccps_pkg::T_BITS;
	localparam int AF = ccps_pkg::ACC_FRAC;
	localparam int LATENCY = 28 + FRAC + 26;
	localparam int LIMIT = 400000;

	typedef struct {
		logic       covered;
		logic [7:0] new_grey;
	} shade_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [11:0]        pixel_x = '0;
	logic [11:0]        pixel_y = '0;
	logic signed [16:0] start_x = '0;
	logic signed [16:0] start_y = '0;
	logic [7:0]         start_radius = '0;
	logic signed [16:0] end_x = '0;
	logic signed [16:0] end_y = '0;
	logic [7:0]         end_radius = '0;
	logic [7:0]         current_grey = '0;
	logic               done;
	logic               covered;
	logic [7:0]         new_grey;

	shade_t shade_q[$];
	int     errors = 0;
	int     cycles = 0;
	bit     no_gaps = 1'b0;

	capsule_coverage_pixel_shader dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cycle watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_capsule_coverage_pixel_shader: FAIL");
			$finish;
		end
	end

	// rounded integer square root
	function automatic longint unsigned sqrt_near(longint unsigned n);
		longint unsigned s, b, rem;
		s = 0;
		b = 64'd1 << 62;
		rem = n;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (rem >= s + b) begin
				rem -= s + b;
				s = (s >> 1) + b;
			end else begin
				s >>= 1;
			end
			b >>= 2;
		end
		if (rem > s) s += 1;
		return s;
	endfunction

	function automatic shade_t shade_pixel(logic [11:0] qx, logic [11:0] qy,
			logic signed [16:0] ax17, logic signed [16:0] ay17, logic [7:0] ra,
			logic signed [16:0] bx17, logic signed [16:0] by17, logic [7:0] rb,
			logic [7:0] cur);
		longint px, py, ax, ay, bx, by, abx, aby, lensq, pax, pay, t, dot;
		longint ddx, ddy, d20, r20, cov;
		longint unsigned mx, my, dq, inv, ink;
		shade_t res;
		px = (longint'(qx) << FRAC) + (64'sd1 << (FRAC - 1));
		py = (longint'(qy) << FRAC) + (64'sd1 << (FRAC - 1));
		ax = ax17; ay = ay17; bx = bx17; by = by17;
		abx = bx - ax; aby = by - ay;
		lensq = abx * abx + aby * aby;
		pax = px - ax; pay = py - ay;
		t = 0;
		if (lensq * 10000 > (64'sd1 << (2 * FRAC))) begin
			dot = pax * abx + pay * aby;
			if (dot <= 0) t = 0;
			else if (dot >= lensq) t = T_ONE;
			else t = (dot * T_ONE + lensq / 2) / lensq;
		end
		ddx = pax * T_ONE - abx * t;
		ddy = pay * T_ONE - aby * t;
		mx = ((ddx < 0 ? -ddx : ddx) + 128) >> 8;
		my = ((ddy < 0 ? -ddy : ddy) + 128) >> 8;
		dq = sqrt_near(mx * mx + my * my);
		d20 = longint'(dq << (12 - FRAC));
		r20 = longint'(ra) * T_ONE + (longint'(rb) - longint'(ra)) * t;
		cov = r20 + (64'sd1 << (AF - 1)) - d20;
		res.covered = 1'b0;
		res.new_grey = cur;
		if (cov > 0) begin
			if (cov > (64'sd1 << AF)) cov = 64'sd1 << AF;
			inv = (64'd1 << AF) - cov;
			ink = (inv * 255 + (64'd1 << (AF - 1))) >> AF;
			if (ink < cur) begin
				res.covered = 1'b1;
				res.new_grey = ink[7:0];
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	// result checker: every done beat pops the oldest expectation
	always @(posedge clk) begin
		shade_t e;
		if (arst_n && done) begin
			if (shade_q.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				e = shade_q.pop_front();
				if (covered !== e.covered) report_mismatch("covered", covered, e.covered);
				if (new_grey !== e.new_grey) report_mismatch("new_grey", new_grey, e.new_grey);
			end
		end
	end

	// one beat: drive at falling edge, accepted at rising edge with busy low
	task automatic send_pixel(logic [11:0] qx, logic [11:0] qy,
			logic signed [16:0] ax, logic signed [16:0] ay, logic [7:0] ra,
			logic signed [16:0] bx, logic signed [16:0] by, logic [7:0] rb,
			logic [7:0] cur);
		while (!no_gaps && $urandom_range(99) < 35) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		pixel_x <= qx; pixel_y <= qy;
		start_x <= ax; start_y <= ay; start_radius <= ra;
		end_x <= bx; end_y <= by; end_radius <= rb;
		current_grey <= cur;
		@(posedge clk);
		while (busy) @(posedge clk);
		shade_q.push_back(shade_pixel(qx, qy, ax, ay, ra, bx, by, rb, cur));
		@(negedge clk);
	endtask

	task automatic test_directed();
		send_pixel(0, 0, 0, 0, 0, 0, 0, 0, 255);
		send_pixel(4095, 4095, 17'sh0FFFF, 17'sh0FFFF, 255, 17'sh0FFFF, 17'sh0FFFF, 255, 255);
		send_pixel(0, 0, -17'sd65536, -17'sd65536, 255, 17'sh0FFFF, 17'sh0FFFF, 255, 255);
		send_pixel(10, 10, 168, 168, 40, 168, 168, 40, 200);     // disc
		send_pixel(10, 10, 168, 168, 40, 168, 169, 40, 200);     // near-degenerate
		send_pixel(2, 10, 100, 168, 16, 400, 168, 64, 255);      // before start
		send_pixel(40, 10, 100, 168, 16, 400, 168, 64, 255);     // past end
		send_pixel(15, 10, 100, 168, 16, 400, 168, 64, 255);     // interior
		send_pixel(15, 10, 100, 168, 16, 400, 168, 64, 0);       // ink not darker
		send_pixel(15, 30, 100, 168, 16, 400, 168, 64, 255);     // no coverage
		send_pixel(15, 11, 100, 168, 16, 400, 168, 64, 255);     // inside band, off axis
		send_pixel(15, 10, 400, 168, 255, 100, 168, 0, 128);
		send_pixel(4095, 0, 17'sh0FFFF, -17'sd65536, 8, 0, 0, 8, 255);
		send_pixel(7, 7, 120, 120, 24, 120, 120, 24, 1);
	endtask

	// random pixels, mostly near a segment so coverage varies
	task automatic test_random(int n);
		logic [11:0] qx, qy;
		logic signed [16:0] ax, ay, bx, by;
		for (int i = 0; i < n; i++) begin
			no_gaps = (i >= n / 3 && i < n / 2);
			if ($urandom_range(9) < 2) begin
				send_pixel(12'($urandom), 12'($urandom), 17'($urandom), 17'($urandom),
					8'($urandom), 17'($urandom), 17'($urandom), 8'($urandom),
					8'($urandom));
			end else begin
				qx = 12'($urandom_range(4095));
				qy = 12'($urandom_range(4095));
				ax = 17'((17'(qx) <<< FRAC) + 17'($urandom_range(400)) - 17'(200));
				ay = 17'((17'(qy) <<< FRAC) + 17'($urandom_range(400)) - 17'(200));
				bx = 17'(ax + $signed(17'($urandom_range(600))) - 17'sd300);
				by = 17'(ay + $signed(17'($urandom_range(600))) - 17'sd300);
				if ($urandom_range(9) == 0) begin bx = ax; by = ay; end
				send_pixel(qx, qy, ax, ay, 8'($urandom), bx, by, 8'($urandom),
					8'($urandom));
			end
		end
		no_gaps = 1'b0;
		start <= 1'b0;
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(650);
		start <= 1'b0;
		while (shade_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) begin
			$display("tb_capsule_coverage_pixel_shader: PASS");
		end else begin
			$display("tb_capsule_coverage_pixel_shader: FAIL");
		end
		$finish;
	end

endmodule
